>>> rtl/asd_pkg.sv
// Shared types and constants for the accelerometer stillness detector.
package asd_pkg;

    localparam int TIME_W   = 48;
    localparam int ACC_W    = 16;
    localparam int MAG_W    = 17;
    localparam int WIN_W    = 16;
    localparam int HOLD_W   = 20;
    localparam int MINS_W   = 9;
    localparam int THR_W    = 16;
    localparam int CNT_OUT_W = 9;
    localparam int CFG_W    = 20;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ROOT_W   = 32;

    // Root search walks two bits per step from bit 30 down to bit 0.
    localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(32'h4000_0000);
    localparam logic [3:0]        ROOT_LAST     = 4'd15;

    localparam logic [WIN_W-1:0]  WINDOW_MS_RST     = 16'd2000;
    localparam logic [HOLD_W-1:0] HOLD_MS_RST       = 20'd10000;
    localparam logic [MINS_W-1:0] MIN_SAMPLES_RST   = 9'd80;
    localparam logic [THR_W-1:0]  STD_THRESHOLD_RST = 16'd41;

    typedef enum logic [1:0] {
        CFG_WINDOW_MS     = 2'd0,
        CFG_HOLD_MS       = 2'd1,
        CFG_MIN_SAMPLES   = 2'd2,
        CFG_STD_THRESHOLD = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef struct packed {
        logic                    op;
        logic [TIME_W-1:0]       time_ms;
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
    } t_in;

    typedef struct packed {
        logic                 stopped;
        logic                 still_now;
        logic [CNT_OUT_W-1:0] window_count;
        logic                 window_overflow;
    } t_out;

    typedef struct packed {
        logic [WIN_W-1:0]  window_ms;
        logic [HOLD_W-1:0] hold_ms;
        logic [MINS_W-1:0] min_samples;
        logic [THR_W-1:0]  std_threshold;
    } t_cfg;

    typedef enum logic [3:0] {
        MUL_X,
        MUL_Y,
        MUL_Z,
        MUL_MAG,
        MUL_OLD,
        MUL_NLO,
        MUL_NHI,
        MUL_SUM,
        MUL_NN,
        MUL_THR,
        MUL_LIM
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     clear_all;
        t_mul_sel mul_sel;
        logic     rv_load;
        logic     rv_add;
        logic     root_step;
        logic     set_ovf;
        logic     drop;
        logic     append;
        logic     lhs_lo;
        logic     lhs_hi;
        logic     sq_load;
        logic     nn_load;
        logic     lim_load;
        logic     judge;
        logic     cand_update;
        logic     hold_check;
        logic     below_min;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic op_clear;
        logic full;
        logic evict;
        logic below_min;
    } t_stat;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OP,
        ST_CLEAR,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQ_SUM,
        ST_ROOT,
        ST_CHK_FULL,
        ST_READ,
        ST_DROP_MUL,
        ST_DROP_SUB,
        ST_APP_MUL,
        ST_APPEND,
        ST_EV_CHK,
        ST_MIN_CHK,
        ST_J_HI,
        ST_J_SQ,
        ST_J_NN,
        ST_J_THR,
        ST_J_LIM,
        ST_J_SPREAD,
        ST_J_TEST,
        ST_CAND,
        ST_HOLD,
        ST_DONE
    } t_state;

    // Magnitude of a two's complement sample; the most negative code maps to 2^15.
    function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] a);
        logic [ACC_W-1:0] u;
        u = a;
        return a[ACC_W-1] ? (~u + ACC_W'(1)) : u;
    endfunction

endpackage

>>> rtl/asd_ctrl.sv
// Sequencer for the stillness detector: steps the datapath through one beat.
module asd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  asd_pkg::t_stat i_stat,
    output asd_pkg::t_cmd  o_cmd
);

    asd_pkg::t_state r_state, n_state;
    logic [3:0]      r_iter, n_iter;
    logic            r_phase_full, n_phase_full;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == asd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= asd_pkg::ST_IDLE;
            r_iter       <= '0;
            r_phase_full <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iter       <= n_iter;
            r_phase_full <= n_phase_full;
            r_out_valid  <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state      = r_state;
        n_iter       = r_iter;
        n_phase_full = r_phase_full;
        n_out_valid  = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            asd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = asd_pkg::ST_OP;
                end
            end
            asd_pkg::ST_OP: begin
                n_state = i_stat.op_clear ? asd_pkg::ST_CLEAR : asd_pkg::ST_SQ_Y;
            end
            asd_pkg::ST_CLEAR:  n_state = asd_pkg::ST_DONE;
            asd_pkg::ST_SQ_Y:   n_state = asd_pkg::ST_SQ_Z;
            asd_pkg::ST_SQ_Z:   n_state = asd_pkg::ST_SQ_SUM;
            asd_pkg::ST_SQ_SUM: begin
                n_state = asd_pkg::ST_ROOT;
                n_iter  = '0;
            end
            asd_pkg::ST_ROOT: begin
                n_iter = r_iter + 4'd1;
                if (r_iter == asd_pkg::ROOT_LAST) begin
                    n_state = asd_pkg::ST_CHK_FULL;
                end
            end
            asd_pkg::ST_CHK_FULL: begin
                n_phase_full = i_stat.full;
                n_state = i_stat.full ? asd_pkg::ST_READ : asd_pkg::ST_APP_MUL;
            end
            asd_pkg::ST_READ: begin
                n_state = r_phase_full ? asd_pkg::ST_DROP_MUL : asd_pkg::ST_EV_CHK;
            end
            asd_pkg::ST_DROP_MUL: n_state = asd_pkg::ST_DROP_SUB;
            asd_pkg::ST_DROP_SUB: begin
                n_state = r_phase_full ? asd_pkg::ST_APP_MUL : asd_pkg::ST_READ;
            end
            asd_pkg::ST_APP_MUL: n_state = asd_pkg::ST_APPEND;
            asd_pkg::ST_APPEND: begin
                n_phase_full = 1'b0;
                n_state      = asd_pkg::ST_READ;
            end
            asd_pkg::ST_EV_CHK: begin
                n_state = i_stat.evict ? asd_pkg::ST_DROP_MUL : asd_pkg::ST_MIN_CHK;
            end
            asd_pkg::ST_MIN_CHK: begin
                n_state = i_stat.below_min ? asd_pkg::ST_DONE : asd_pkg::ST_J_HI;
            end
            asd_pkg::ST_J_HI:     n_state = asd_pkg::ST_J_SQ;
            asd_pkg::ST_J_SQ:     n_state = asd_pkg::ST_J_NN;
            asd_pkg::ST_J_NN:     n_state = asd_pkg::ST_J_THR;
            asd_pkg::ST_J_THR:    n_state = asd_pkg::ST_J_LIM;
            asd_pkg::ST_J_LIM:    n_state = asd_pkg::ST_J_SPREAD;
            asd_pkg::ST_J_SPREAD: n_state = asd_pkg::ST_J_TEST;
            asd_pkg::ST_J_TEST:   n_state = asd_pkg::ST_CAND;
            asd_pkg::ST_CAND:     n_state = asd_pkg::ST_HOLD;
            asd_pkg::ST_HOLD:     n_state = asd_pkg::ST_DONE;
            asd_pkg::ST_DONE: begin
                // Hold until the output register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = asd_pkg::ST_IDLE;
                end
            end
            default: n_state = asd_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = asd_pkg::MUL_X;
        unique case (r_state)
            asd_pkg::ST_IDLE:     o_cmd.load_in = i_in_valid;
            asd_pkg::ST_OP:       o_cmd.mul_sel = asd_pkg::MUL_X;
            asd_pkg::ST_CLEAR:    o_cmd.clear_all = 1'b1;
            asd_pkg::ST_SQ_Y: begin
                o_cmd.rv_load = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_Y;
            end
            asd_pkg::ST_SQ_Z: begin
                o_cmd.rv_add  = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_Z;
            end
            asd_pkg::ST_SQ_SUM:   o_cmd.rv_add = 1'b1;
            asd_pkg::ST_ROOT:     o_cmd.root_step = 1'b1;
            asd_pkg::ST_CHK_FULL: o_cmd.set_ovf = i_stat.full;
            asd_pkg::ST_READ:     o_cmd.mul_sel = asd_pkg::MUL_X;
            asd_pkg::ST_DROP_MUL: o_cmd.mul_sel = asd_pkg::MUL_OLD;
            asd_pkg::ST_DROP_SUB: o_cmd.drop = 1'b1;
            asd_pkg::ST_APP_MUL:  o_cmd.mul_sel = asd_pkg::MUL_MAG;
            asd_pkg::ST_APPEND:   o_cmd.append = 1'b1;
            asd_pkg::ST_EV_CHK:   o_cmd.mul_sel = asd_pkg::MUL_X;
            asd_pkg::ST_MIN_CHK: begin
                o_cmd.mul_sel   = asd_pkg::MUL_NLO;
                o_cmd.below_min = i_stat.below_min;
            end
            asd_pkg::ST_J_HI: begin
                o_cmd.lhs_lo  = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_NHI;
            end
            asd_pkg::ST_J_SQ: begin
                o_cmd.lhs_hi  = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_SUM;
            end
            asd_pkg::ST_J_NN: begin
                o_cmd.sq_load = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_NN;
            end
            asd_pkg::ST_J_THR: begin
                o_cmd.nn_load = 1'b1;
                o_cmd.mul_sel = asd_pkg::MUL_THR;
            end
            asd_pkg::ST_J_LIM:    o_cmd.mul_sel = asd_pkg::MUL_LIM;
            asd_pkg::ST_J_SPREAD: o_cmd.lim_load = 1'b1;
            asd_pkg::ST_J_TEST:   o_cmd.judge = 1'b1;
            asd_pkg::ST_CAND:     o_cmd.cand_update = 1'b1;
            asd_pkg::ST_HOLD:     o_cmd.hold_check = 1'b1;
            asd_pkg::ST_DONE:     o_cmd.out_load = out_free;
            default:              o_cmd.mul_sel = asd_pkg::MUL_X;
        endcase
    end

endmodule

>>> rtl/asd_datapath.sv
// Datapath: sample store, running sums, shared multiplier, root unit, result register.
module asd_datapath #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asd_pkg::t_in   i_in_data,
    input  asd_pkg::t_cfg  i_cfg,
    input  asd_pkg::t_cmd  i_cmd,
    output asd_pkg::t_stat o_stat,
    output asd_pkg::t_out  o_out_data
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = asd_pkg::MAG_W + IDX_W;
    localparam int SQS_W  = 2 * asd_pkg::MAG_W + IDX_W;
    localparam int HALF_W = (SQS_W + 1) / 2;
    localparam int HI_W   = SQS_W - HALF_W;
    localparam int LHS_W  = CNT_W + SQS_W;
    localparam int NN_W   = 2 * CNT_W;
    localparam int MINC_W = (CNT_W > asd_pkg::MINS_W) ? CNT_W : asd_pkg::MINS_W;
    localparam int MUL_W  = asd_pkg::MUL_W;

    // Sample store.
    logic [asd_pkg::TIME_W-1:0] time_mem [WINDOW_DEPTH];
    logic [asd_pkg::MAG_W-1:0]  mag_mem  [WINDOW_DEPTH];
    logic [asd_pkg::TIME_W-1:0] r_rd_time;
    logic [asd_pkg::MAG_W-1:0]  r_rd_mag;

    asd_pkg::t_in              r_in;
    logic [IDX_W-1:0]          r_oldest;
    logic [CNT_W-1:0]          r_count;
    logic [SUM_W-1:0]          r_sum;
    logic [SQS_W-1:0]          r_sumsq;
    logic                      r_cand_valid;
    logic [asd_pkg::TIME_W-1:0] r_cand_start;
    logic                      r_stopped;
    logic                      r_still;
    logic                      r_ovf;

    logic [asd_pkg::ROOT_W-1:0] r_rv, r_res, r_bit;
    logic [asd_pkg::PROD_W-1:0] r_prod;
    logic [LHS_W-1:0]           r_lhs, r_sq, r_lim, r_spread;
    logic [NN_W-1:0]            r_nn;
    asd_pkg::t_out              r_out;

    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [asd_pkg::ROOT_W-1:0] trial;
    logic [asd_pkg::MAG_W-1:0]  mag;
    logic [CNT_W:0]             slot_sum;
    logic [IDX_W-1:0]           slot;
    logic [asd_pkg::TIME_W-1:0] age;
    logic [asd_pkg::TIME_W-1:0] held;

    assign mag   = r_res[asd_pkg::MAG_W-1:0];
    assign trial = r_res + r_bit;
    assign age   = r_in.time_ms - r_rd_time;
    assign held  = r_in.time_ms - r_cand_start;

    always_comb begin
        slot_sum = (CNT_W + 1)'(r_oldest) + (CNT_W + 1)'(r_count);
        if (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
            slot_sum = slot_sum - (CNT_W + 1)'(WINDOW_DEPTH);
        end
        slot = slot_sum[IDX_W-1:0];
    end

    assign o_stat.op_clear  = (asd_pkg::t_op'(r_in.op) == asd_pkg::OP_CLEAR);
    assign o_stat.full      = (r_count == CNT_W'(WINDOW_DEPTH));
    assign o_stat.evict     = (r_count != '0) && (r_in.time_ms >= r_rd_time) &&
                              (age > asd_pkg::TIME_W'(i_cfg.window_ms));
    assign o_stat.below_min = (MINC_W'(r_count) < MINC_W'(i_cfg.min_samples));
    assign o_out_data       = r_out;

    // Shared multiplier operand select.
    always_comb begin
        unique case (i_cmd.mul_sel)
            asd_pkg::MUL_X: begin
                mul_a = MUL_W'(asd_pkg::abs_acc(r_in.accel_x));
                mul_b = mul_a;
            end
            asd_pkg::MUL_Y: begin
                mul_a = MUL_W'(asd_pkg::abs_acc(r_in.accel_y));
                mul_b = mul_a;
            end
            asd_pkg::MUL_Z: begin
                mul_a = MUL_W'(asd_pkg::abs_acc(r_in.accel_z));
                mul_b = mul_a;
            end
            asd_pkg::MUL_MAG: begin
                mul_a = MUL_W'(mag);
                mul_b = mul_a;
            end
            asd_pkg::MUL_OLD: begin
                mul_a = MUL_W'(r_rd_mag);
                mul_b = mul_a;
            end
            asd_pkg::MUL_NLO: begin
                mul_a = MUL_W'(r_count);
                mul_b = MUL_W'(r_sumsq[HALF_W-1:0]);
            end
            asd_pkg::MUL_NHI: begin
                mul_a = MUL_W'(r_count);
                mul_b = MUL_W'(r_sumsq[SQS_W-1 -: HI_W]);
            end
            asd_pkg::MUL_SUM: begin
                mul_a = MUL_W'(r_sum);
                mul_b = mul_a;
            end
            asd_pkg::MUL_NN: begin
                mul_a = MUL_W'(r_count);
                mul_b = mul_a;
            end
            asd_pkg::MUL_THR: begin
                mul_a = MUL_W'(i_cfg.std_threshold);
                mul_b = mul_a;
            end
            asd_pkg::MUL_LIM: begin
                mul_a = MUL_W'(r_nn);
                mul_b = r_prod[MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= asd_pkg::PROD_W'(mul_a) * asd_pkg::PROD_W'(mul_b);
    end

    // Store: write the new sample, read the oldest entry every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            time_mem[slot] <= r_in.time_ms;
            mag_mem[slot]  <= mag;
        end
        r_rd_time <= time_mem[r_oldest];
        r_rd_mag  <= mag_mem[r_oldest];
    end

    // Payload and scratch registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.rv_load) begin
            r_rv  <= r_prod[asd_pkg::ROOT_W-1:0];
            r_res <= '0;
            r_bit <= asd_pkg::ROOT_BIT_INIT;
        end else if (i_cmd.rv_add) begin
            r_rv <= r_rv + r_prod[asd_pkg::ROOT_W-1:0];
        end else if (i_cmd.root_step) begin
            if (r_rv >= trial) begin
                r_rv  <= r_rv - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.lhs_lo) begin
            r_lhs <= LHS_W'(r_prod);
        end
        if (i_cmd.lhs_hi) begin
            r_lhs <= r_lhs + (LHS_W'(r_prod) << HALF_W);
        end
        if (i_cmd.sq_load) begin
            r_sq <= LHS_W'(r_prod);
        end
        if (i_cmd.nn_load) begin
            r_nn <= NN_W'(r_prod);
        end
        if (i_cmd.lim_load) begin
            r_lim    <= LHS_W'(r_prod);
            r_spread <= (r_lhs >= r_sq) ? (r_lhs - r_sq) : '0;
        end
        if (i_cmd.out_load) begin
            r_out.stopped         <= r_stopped;
            r_out.still_now       <= r_still;
            r_out.window_count    <= asd_pkg::CNT_OUT_W'(r_count);
            r_out.window_overflow <= r_ovf;
        end
    end

    // Window and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest     <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_cand_valid <= 1'b0;
            r_cand_start <= '0;
            r_stopped    <= 1'b0;
            r_still      <= 1'b0;
            r_ovf        <= 1'b0;
        end else if (i_cmd.clear_all) begin
            r_oldest     <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_cand_valid <= 1'b0;
            r_cand_start <= '0;
            r_stopped    <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_still <= 1'b0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.drop) begin
                r_sum   <= r_sum - SUM_W'(r_rd_mag);
                r_sumsq <= r_sumsq - SQS_W'(r_prod);
                r_count <= r_count - CNT_W'(1);
                r_oldest <= (r_oldest == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : r_oldest + IDX_W'(1);
            end
            if (i_cmd.append) begin
                r_sum   <= r_sum + SUM_W'(mag);
                r_sumsq <= r_sumsq + SQS_W'(r_prod);
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.below_min) begin
                r_cand_valid <= 1'b0;
                r_cand_start <= '0;
                r_stopped    <= 1'b0;
            end
            if (i_cmd.judge) begin
                r_still <= (r_spread < r_lim);
            end
            if (i_cmd.cand_update) begin
                if (r_still) begin
                    if (!r_cand_valid) begin
                        r_cand_valid <= 1'b1;
                        r_cand_start <= r_in.time_ms;
                    end
                end else begin
                    r_cand_valid <= 1'b0;
                    r_cand_start <= '0;
                    r_stopped    <= 1'b0;
                end
            end
            if (i_cmd.hold_check && r_still && (r_in.time_ms >= r_cand_start) &&
                (held >= asd_pkg::TIME_W'(i_cfg.hold_ms))) begin
                r_stopped <= 1'b1;
            end
        end
    end

endmodule

>>> rtl/accel_stillness_detector_unit.sv
// Top level of the accelerometer stillness detector.
// Each input beat is a push of a timestamped three-axis sample or a clear. A push forms
// the floor square root of x^2+y^2+z^2, appends it to a store of WINDOW_DEPTH entries,
// evicts entries older than window_ms, and, once min_samples are held, tests the window
// with n*sumsq - sum^2 < n^2*std_threshold^2. Stillness that lasts hold_ms sets stopped.
// Every beat in gives exactly one result beat. Items are worked one at a time: a push
// squares the three axes, takes the root, drops the oldest entry when the store is
// full, appends the new one, evicts stale entries one by one and, unless fewer than
// min_samples are held, runs the test; a clear empties the window. The block is ready
// for the next beat in the same cycle as the result rises. The work is paced by the
// 16-step root unit, which takes two radicand bits per step, and by the single 32x32
// multiplier that all squares and products share. A finished result waits in the
// output register, so the next beat is accepted while it is unread; a second result
// holds until the first is taken. Configuration writes take effect at once and should
// be made only while the block is idle.
module accel_stillness_detector_unit #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  asd_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output asd_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [asd_pkg::CFG_W-1:0]  i_cfg_data
);

    asd_pkg::t_cfg  r_cfg;
    asd_pkg::t_cmd  cmd;
    asd_pkg::t_stat stat;

    // Configuration registers: plain writes, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ms     <= asd_pkg::WINDOW_MS_RST;
            r_cfg.hold_ms       <= asd_pkg::HOLD_MS_RST;
            r_cfg.min_samples   <= asd_pkg::MIN_SAMPLES_RST;
            r_cfg.std_threshold <= asd_pkg::STD_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (asd_pkg::t_cfg_idx'(i_cfg_index))
                asd_pkg::CFG_WINDOW_MS:
                    r_cfg.window_ms <= i_cfg_data[asd_pkg::WIN_W-1:0];
                asd_pkg::CFG_HOLD_MS:
                    r_cfg.hold_ms <= i_cfg_data[asd_pkg::HOLD_W-1:0];
                asd_pkg::CFG_MIN_SAMPLES:
                    r_cfg.min_samples <= i_cfg_data[asd_pkg::MINS_W-1:0];
                asd_pkg::CFG_STD_THRESHOLD:
                    r_cfg.std_threshold <= i_cfg_data[asd_pkg::THR_W-1:0];
            endcase
        end
    end

    // Sequencer: owns the handshakes and steps the datapath.
    asd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: store, sums, multiplier, root unit and result register.
    asd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

>>> test/stillness_checker.sv
// Watches the detector's channels, predicts each result and compares it field by field.
`timescale 1ns / 1ps

module stillness_checker #(
    parameter int DEPTH = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  asd_pkg::t_in              i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  asd_pkg::t_out             i_out_data,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [asd_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic [asd_pkg::WIN_W-1:0]  win_ms;
    logic [asd_pkg::HOLD_W-1:0] hold_ms;
    logic [asd_pkg::MINS_W-1:0] min_cnt;
    logic [asd_pkg::THR_W-1:0]  thr;

    logic [asd_pkg::TIME_W-1:0] stamp_mem [DEPTH];
    longint unsigned   mag_mem   [DEPTH];
    int                head;
    int                count;
    longint unsigned   sum_mag;
    longint unsigned   sum_sq;
    logic              cand_on;
    logic [asd_pkg::TIME_W-1:0] cand_t0;
    logic              stop_flag;

    asd_pkg::t_out result_q [$];

    function automatic longint unsigned axis_sq(logic signed [asd_pkg::ACC_W-1:0] a);
        longint signed s;
        s = a;
        return longint'(s * s);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void drop_head();
        sum_mag -= mag_mem[head];
        sum_sq  -= mag_mem[head] * mag_mem[head];
        head = (head + 1) % DEPTH;
        count--;
    endfunction

    function automatic void empty_window();
        head = 0; count = 0; sum_mag = 0; sum_sq = 0;
        cand_on = 0; cand_t0 = '0; stop_flag = 0;
    endfunction

    // Advance the window by one beat and return the result it should produce.
    function automatic asd_pkg::t_out step_window(asd_pkg::t_in it);
        asd_pkg::t_out r;
        longint unsigned m, n, lhs, sq, spread, lim, th;
        logic ovf;
        logic still;
        int slot;
        r = '0;
        ovf = 0;
        still = 0;
        if (it.op == asd_pkg::OP_CLEAR) begin
            empty_window();
            return r;
        end
        m = isqrt(axis_sq(it.accel_x) + axis_sq(it.accel_y) + axis_sq(it.accel_z));
        if (count >= DEPTH) begin
            drop_head();
            ovf = 1;
        end
        slot = (head + count) % DEPTH;
        stamp_mem[slot] = it.time_ms;
        mag_mem[slot]   = m;
        count++;
        sum_mag += m;
        sum_sq  += m * m;
        // Evict stale entries; an entry newer than this sample stays.
        while (count > 0 && it.time_ms >= stamp_mem[head]
               && it.time_ms - stamp_mem[head] > win_ms)
            drop_head();
        if (count < min_cnt) begin
            cand_on = 0; cand_t0 = '0; stop_flag = 0;
        end else begin
            n = count;
            lhs = n * sum_sq;
            sq = sum_mag * sum_mag;
            spread = (lhs >= sq) ? lhs - sq : 0;
            th = thr;
            lim = n * n * (th * th);
            if (spread < lim) begin
                still = 1;
                if (!cand_on) begin
                    cand_on = 1;
                    cand_t0 = it.time_ms;
                end
                if (it.time_ms >= cand_t0 && it.time_ms - cand_t0 >= hold_ms)
                    stop_flag = 1;
            end else begin
                cand_on = 0; cand_t0 = '0; stop_flag = 0;
            end
        end
        r.stopped = stop_flag;
        r.still_now = still;
        r.window_count = asd_pkg::CNT_OUT_W'(count);
        r.window_overflow = ovf;
        return r;
    endfunction

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        asd_pkg::t_out want;
        if (!i_rst_n) begin
            win_ms = asd_pkg::WINDOW_MS_RST; hold_ms = asd_pkg::HOLD_MS_RST;
            min_cnt = asd_pkg::MIN_SAMPLES_RST; thr = asd_pkg::STD_THRESHOLD_RST;
            empty_window();
            result_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (asd_pkg::t_cfg_idx'(i_cfg_index))
                    asd_pkg::CFG_WINDOW_MS:     win_ms  = i_cfg_data[asd_pkg::WIN_W-1:0];
                    asd_pkg::CFG_HOLD_MS:       hold_ms = i_cfg_data[asd_pkg::HOLD_W-1:0];
                    asd_pkg::CFG_MIN_SAMPLES:   min_cnt = i_cfg_data[asd_pkg::MINS_W-1:0];
                    asd_pkg::CFG_STD_THRESHOLD: thr     = i_cfg_data[asd_pkg::THR_W-1:0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (want != i_out_data) begin
                        if (want.stopped != i_out_data.stopped)
                            $error("stopped: expected %0d actual %0d",
                                   want.stopped, i_out_data.stopped);
                        if (want.still_now != i_out_data.still_now)
                            $error("still_now: expected %0d actual %0d",
                                   want.still_now, i_out_data.still_now);
                        if (want.window_count != i_out_data.window_count)
                            $error("window_count: expected %0d actual %0d",
                                   want.window_count, i_out_data.window_count);
                        if (want.window_overflow != i_out_data.window_overflow)
                            $error("window_overflow: expected %0d actual %0d",
                                   want.window_overflow, i_out_data.window_overflow);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                result_q.insert(result_q.size(), step_window(i_in_data));
        end
    end

endmodule

>>> test/tb_top.sv
// Stimulus and verdict for the accelerometer stillness detector.
`timescale 1ns / 1ps

module tb_top;

    logic             i_clk;
    logic             i_rst_n;
    logic             in_valid;
    logic             in_ready;
    asd_pkg::t_in     in_data;
    logic             out_valid;
    logic             out_ready;
    asd_pkg::t_out    out_data;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [asd_pkg::CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    // Sender side idles only while this is low.
    logic             calm;
    logic [asd_pkg::TIME_W-1:0] now_ms;
    logic signed [asd_pkg::ACC_W-1:0] base_x, base_y, base_z;

    accel_stillness_detector_unit #(.WINDOW_DEPTH(256)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    stillness_checker #(.DEPTH(256)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #30ms;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: stall about 8 beats in a hundred, never while calm.
    always @(negedge i_clk)
        out_ready <= calm || ($urandom_range(99) >= 8);

    // Hand one beat to the block; returns at the falling edge after acceptance.
    task automatic send_beat(asd_pkg::t_in it);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid <= 1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic push_at(logic [asd_pkg::TIME_W-1:0] t, int x, int y, int z);
        asd_pkg::t_in it;
        it.op = asd_pkg::OP_PUSH;
        it.time_ms = t;
        it.accel_x = asd_pkg::ACC_W'(x);
        it.accel_y = asd_pkg::ACC_W'(y);
        it.accel_z = asd_pkg::ACC_W'(z);
        send_beat(it);
    endtask

    task automatic clear_beat();
        asd_pkg::t_in it;
        it = '0;
        it.op = asd_pkg::OP_CLEAR;
        it.time_ms = asd_pkg::TIME_W'({$urandom, $urandom});
        it.accel_x = asd_pkg::ACC_W'($urandom);
        it.accel_y = asd_pkg::ACC_W'($urandom);
        it.accel_z = asd_pkg::ACC_W'($urandom);
        send_beat(it);
    endtask

    // Hold the sender until every result is back, then let the block settle.
    task automatic drain();
        in_valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(asd_pkg::t_cfg_idx idx, logic [asd_pkg::CFG_W-1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 0;
    endtask

    task automatic set_all(int w, int h, int m, int s);
        drain();
        write_reg(asd_pkg::CFG_WINDOW_MS, asd_pkg::CFG_W'(w));
        write_reg(asd_pkg::CFG_HOLD_MS, asd_pkg::CFG_W'(h));
        write_reg(asd_pkg::CFG_MIN_SAMPLES, asd_pkg::CFG_W'(m));
        write_reg(asd_pkg::CFG_STD_THRESHOLD, asd_pkg::CFG_W'(s));
        @(negedge i_clk);
    endtask

    // Mostly steady samples around a base with small noise; some motion,
    // full-scale noise, time jumps backward and clears mixed in.
    task automatic random_phase(int beats, int step_max, int noise);
        int pick;
        int nz;
        now_ms = asd_pkg::TIME_W'({$urandom, $urandom} >> $urandom_range(47, 0));
        base_x = asd_pkg::ACC_W'(int'($urandom_range(2000)) - 1000);
        base_y = asd_pkg::ACC_W'(int'($urandom_range(2000)) - 1000);
        base_z = asd_pkg::ACC_W'(int'($urandom_range(2000)) + 1500);
        for (int k = 0; k < beats; k++) begin
            if (k % 300 == 100) calm = 1;
            if (k % 300 == 180) calm = 0;
            pick = $urandom_range(99);
            nz = (pick < 10) ? 600 : noise;
            if (pick < 2) begin
                clear_beat();
            end else if (pick < 6) begin
                push_at(asd_pkg::TIME_W'({$urandom, $urandom}), int'($urandom),
                        int'($urandom), int'($urandom));
            end else begin
                if (pick < 9) now_ms = now_ms - $urandom_range(step_max * 3);
                else now_ms = now_ms + $urandom_range(step_max);
                push_at(now_ms, base_x + $urandom_range(2 * nz) - nz,
                        base_y + $urandom_range(2 * nz) - nz,
                        base_z + $urandom_range(2 * nz) - nz);
            end
        end
        calm = 0;
    endtask

    initial begin
        i_rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = asd_pkg::CFG_WINDOW_MS;
        cfg_data = '0;
        calm = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: axis extremes, a clear, a time step back, top of the time range.
        push_at(48'd0, -32768, -32768, -32768);
        push_at(48'd1, 32767, 32767, 32767);
        push_at(48'd1, 0, 0, 0);
        push_at(48'd2, -1, 1, -32768);
        clear_beat();
        push_at(48'hFFFF_FFFF_FFFF, 32767, -32768, 0);
        push_at(48'hFFFF_FFFF_FFF0, 100, 100, 100);
        push_at(48'h0000_0000_0005, 100, 100, 100);
        set_all(5, 0, 1, 65535);
        push_at(48'd100, 256, 0, 0);
        push_at(48'd101, 256, 0, 0);
        push_at(48'd90, 256, 0, 0);
        push_at(48'd200, 0, 0, 2560);
        set_all(5, 3, 2, 0);
        push_at(48'd10, 500, 0, 0);
        push_at(48'd11, 500, 0, 0);
        set_all(10, 3, 2, 8);
        push_at(48'd20, 500, 0, 0);
        push_at(48'd21, 500, 0, 0);
        push_at(48'd24, 500, 0, 0);
        push_at(48'd22, 500, 0, 0);
        push_at(48'd26, 4000, 0, 0);
        clear_beat();

        set_all(50, 100, 4, 30);
        random_phase(400, 8, 8);
        set_all(1, 0, 1, 65535);
        random_phase(200, 2, 20);
        // Huge window and hold: the store fills and overflows.
        set_all(65535, 1048575, 256, 65535);
        random_phase(350, 1, 40);
        set_all(200, 0, 511, 0);
        random_phase(150, 5, 8);
        set_all(100, 40, 16, 12);
        random_phase(500, 6, 6);
        set_all(2000, 10000, 80, 41);
        random_phase(400, 40, 10);

        drain();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
